### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on i_clk, off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### design/cbfm_pkg.sv
// ----------------------------------------------------------------------------
// cbfm_pkg
// Shared constants for the constrained basis table and flip-row generator.
// ----------------------------------------------------------------------------
`default_nettype none

package cbfm_pkg;

    // parameter defaults
    localparam int MAX_SITES_DEF   = 10;
    localparam int TABLE_DEPTH_DEF = 256;

    // fixed field widths
    localparam int KET_W       = 8;
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int WEIGHT_W    = 2;
    localparam int STATUS_W    = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SITES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_MODE = 2'd2;

    // configuration reset values
    localparam logic [CFG_W-1:0] NUM_SITES_RST = 4'd10;
    localparam logic             PERIODIC_RST  = 1'b1;
    localparam logic             PAIR_MODE_RST = 1'b1;

    // commands
    localparam logic CMD_BUILD = 1'b0;
    localparam logic CMD_ROW   = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // matrix element values
    localparam logic [WEIGHT_W-1:0] WT_NONE = 2'd0;
    localparam logic [WEIGHT_W-1:0] WT_ONE  = 2'd1;
    localparam logic [WEIGHT_W-1:0] WT_TWO  = 2'd2;

endpackage

`default_nettype wire

### design/cbfm_legal.sv
// ----------------------------------------------------------------------------
// cbfm_legal
// Neighbor-exclusion check of one basis word, shared by build and row flips.
// ----------------------------------------------------------------------------
`default_nettype none

module cbfm_legal #(
    parameter int MAX_SITES = cbfm_pkg::MAX_SITES_DEF,
    localparam int JW = $clog2(MAX_SITES + 1)
) (
    input  wire logic [MAX_SITES-1:0] i_word,
    input  wire logic [JW-1:0]        i_num_sites,
    input  wire logic                 i_periodic,
    output logic                      o_legal
);

    import cbfm_pkg::*;

    logic [JW-1:0]        pairs;
    logic [MAX_SITES-1:0] nxt;
    logic [MAX_SITES-1:0] chk;

    // periodic: n neighbor pairs, open: n-1
    assign pairs = i_periodic ? i_num_sites : (i_num_sites - JW'(1));

    for (genvar g = 0; g < MAX_SITES; g++) begin : g_site
        if (g == MAX_SITES - 1) begin : g_top
            assign nxt[g] = i_word[0];
        end else begin : g_mid
            assign nxt[g] = (JW'(g + 1) == i_num_sites) ? i_word[0] : i_word[g + 1];
        end
        assign chk[g] = (JW'(g) < pairs);
    end

    assign o_legal = ~|(i_word & nxt & chk);

endmodule

`default_nettype wire

### design/cbfm_table.sv
// ----------------------------------------------------------------------------
// cbfm_table
// Basis word memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cbfm_table #(
    parameter int MAX_SITES   = cbfm_pkg::MAX_SITES_DEF,
    parameter int TABLE_DEPTH = cbfm_pkg::TABLE_DEPTH_DEF,
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_wr_en,
    input  wire logic [ADDR_W-1:0]    i_wr_addr,
    input  wire logic [MAX_SITES-1:0] i_wr_data,
    input  wire logic [ADDR_W-1:0]    i_rd_addr,
    output logic [MAX_SITES-1:0]      o_rd_data
);

    import cbfm_pkg::*;

    logic [MAX_SITES-1:0] mem [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= mem[i_rd_addr];
    end

endmodule

`default_nettype wire

### design/constrained_basis_flip_matrix_rows.sv
// Build: enumerate all 2^n words and store the legal ones, then the result (n = sites in use).
// Row: fetch the ket word from the table, then for each flip candidate a legality
//   check; a legal flip runs a binary search over the table read port, then a
//   hit check, and a miss ends the row.
// One transaction at a time: o_in_ready is high only in the idle state.
// Reset (synchronous, i_rst_n low): config to 10 sites / periodic / pair mode,
//   table count to zero, sequencer idle, output empty. Table memory is not cleared.
// ----------------------------------------------------------------------------
// constrained_basis_flip_matrix_rows
// Builds a table of basis words with no two adjacent set bits, then emits
// (ket, bra, weight) matrix entries for single or pair bit flips of a ket.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module constrained_basis_flip_matrix_rows #(
    parameter int MAX_SITES   = cbfm_pkg::MAX_SITES_DEF,
    parameter int TABLE_DEPTH = cbfm_pkg::TABLE_DEPTH_DEF,
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration write port
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [cbfm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [cbfm_pkg::CFG_W-1:0]       i_cfg_data,
    // input channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic                             i_cmd,
    input  wire logic [cbfm_pkg::KET_W-1:0]       i_ket_index,
    // output channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [cbfm_pkg::KET_W-1:0]            o_ket_out,
    output logic [ADDR_W-1:0]                     o_bra_index,
    output logic [cbfm_pkg::WEIGHT_W-1:0]         o_weight,
    output logic [CNT_W-1:0]                      o_table_size,
    output logic [cbfm_pkg::STATUS_W-1:0]         o_status,
    output logic                                  o_last
);

    import cbfm_pkg::*;

    localparam int W  = MAX_SITES;
    localparam int JW = $clog2(MAX_SITES + 1);
    localparam int CW = (CNT_W > KET_W) ? CNT_W : KET_W;

    // sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_BUILD     = 4'd1;
    localparam logic [3:0] S_SRC_RD    = 4'd2;
    localparam logic [3:0] S_SRC_LATCH = 4'd3;
    localparam logic [3:0] S_FLIP      = 4'd4;
    localparam logic [3:0] S_LOOK      = 4'd5;
    localparam logic [3:0] S_CMP       = 4'd6;
    localparam logic [3:0] S_HIT_RD    = 4'd7;
    localparam logic [3:0] S_HIT_CMP   = 4'd8;
    localparam logic [3:0] S_PUSH      = 4'd9;
    localparam logic [3:0] S_TAIL      = 4'd10;

    // configuration
    logic [CFG_W-1:0]    r_num_sites, n_num_sites;
    logic                r_periodic, n_periodic;
    logic                r_pair_mode, n_pair_mode;

    // sequencer and datapath
    logic [3:0]          r_state, n_state;
    logic [W-1:0]        r_w, n_w;            // build enumeration word
    logic [CNT_W-1:0]    r_count, n_count;    // legal words in table
    logic [KET_W-1:0]    r_ket, n_ket;
    logic [W-1:0]        r_src, n_src;        // ket word
    logic [JW-1:0]       r_j1, n_j1;
    logic [JW-1:0]       r_j2, n_j2;
    logic [W-1:0]        r_word, n_word;      // flipped word under search
    logic [WEIGHT_W-1:0] r_wt, n_wt;
    logic [CNT_W-1:0]    r_lo, n_lo;
    logic [CNT_W-1:0]    r_hi, n_hi;
    logic [ADDR_W-1:0]   r_mid, n_mid;

    // one held-back hit, so the final one can carry last
    logic                r_pend_valid, n_pend_valid;
    logic [ADDR_W-1:0]   r_pend_bra, n_pend_bra;
    logic [WEIGHT_W-1:0] r_pend_wt, n_pend_wt;

    // closing result of a transaction: build done, ket out of range, or miss
    logic                r_tail, n_tail;
    logic [STATUS_W-1:0] r_tail_st, n_tail_st;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [KET_W-1:0]    r_out_ket, n_out_ket;
    logic [ADDR_W-1:0]   r_out_bra, n_out_bra;
    logic [WEIGHT_W-1:0] r_out_wt, n_out_wt;
    logic [CNT_W-1:0]    r_out_size, n_out_size;
    logic [STATUS_W-1:0] r_out_st, n_out_st;
    logic                r_out_last, n_out_last;

    // combinational helpers
    logic [JW-1:0]       n_use;
    logic [W-1:0]        last_word;
    logic [W-1:0]        flip_word;
    logic [W-1:0]        chk_word;
    logic                legal;
    logic                pair_step;
    logic                row_done;
    logic [CNT_W-1:0]    mid;
    logic [CNT_W-1:0]    lo_nx;
    logic [CNT_W-1:0]    hi_nx;
    logic                slot_free;
    logic                out_ld;
    logic [ADDR_W-1:0]   ld_bra;
    logic [WEIGHT_W-1:0] ld_wt;
    logic [STATUS_W-1:0] ld_st;
    logic                ld_last;
    logic                tbl_wr_en;
    logic [ADDR_W-1:0]   tbl_rd_addr;
    logic [W-1:0]        tbl_rd_data;

    // site count clamped to 2..MAX_SITES
    always_comb begin
        if (r_num_sites < CFG_W'(2)) begin
            n_use = JW'(2);
        end else if (r_num_sites > CFG_W'(MAX_SITES)) begin
            n_use = JW'(MAX_SITES);
        end else begin
            n_use = JW'(r_num_sites);
        end
    end

    assign last_word = ~({W{1'b1}} << n_use);
    assign flip_word = r_src ^ (W'(1) << r_j1) ^ (r_pair_mode ? (W'(1) << r_j2) : '0);
    // the one legality unit serves enumeration during build and flips during a row
    assign chk_word  = (r_state == S_BUILD) ? r_w : flip_word;

    cbfm_legal #(
        .MAX_SITES   (MAX_SITES)
    ) u_legal (
        .i_word      (chk_word),
        .i_num_sites (n_use),
        .i_periodic  (r_periodic),
        .o_legal     (legal)
    );

    // flip order: j1 ascending, and in pair mode j2 from j1 up
    assign pair_step = r_pair_mode && ((r_j2 + JW'(1)) < n_use);
    assign row_done  = !pair_step && ((r_j1 + JW'(1)) >= n_use);

    // lower-bound search step
    assign mid   = r_lo + ((r_hi - r_lo) >> 1);
    assign lo_nx = (tbl_rd_data < r_word) ? (CNT_W'(r_mid) + CNT_W'(1)) : r_lo;
    assign hi_nx = (tbl_rd_data < r_word) ? r_hi : CNT_W'(r_mid);

    assign tbl_wr_en   = (r_state == S_BUILD) && legal && (r_count < CNT_W'(TABLE_DEPTH));
    assign tbl_rd_addr = (r_state == S_SRC_RD) ? ADDR_W'(r_ket) :
                         (r_state == S_LOOK)   ? ADDR_W'(mid)   : ADDR_W'(r_lo);

    cbfm_table #(
        .MAX_SITES   (MAX_SITES),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk       (i_clk),
        .i_wr_en     (tbl_wr_en),
        .i_wr_addr   (ADDR_W'(r_count)),
        .i_wr_data   (r_w),
        .i_rd_addr   (tbl_rd_addr),
        .o_rd_data   (tbl_rd_data)
    );

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_num_sites  = r_num_sites;
        n_periodic   = r_periodic;
        n_pair_mode  = r_pair_mode;
        n_state      = r_state;
        n_w          = r_w;
        n_count      = r_count;
        n_ket        = r_ket;
        n_src        = r_src;
        n_j1         = r_j1;
        n_j2         = r_j2;
        n_word       = r_word;
        n_wt         = r_wt;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_pend_valid = r_pend_valid;
        n_pend_bra   = r_pend_bra;
        n_pend_wt    = r_pend_wt;
        n_tail       = r_tail;
        n_tail_st    = r_tail_st;
        n_out_valid  = r_out_valid;
        n_out_ket    = r_out_ket;
        n_out_bra    = r_out_bra;
        n_out_wt     = r_out_wt;
        n_out_size   = r_out_size;
        n_out_st     = r_out_st;
        n_out_last   = r_out_last;
        out_ld       = 1'b0;
        ld_bra       = r_pend_bra;
        ld_wt        = r_pend_wt;
        ld_st        = ST_OK;
        ld_last      = 1'b0;

        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_NUM_SITES: n_num_sites = i_cfg_data;
                CFG_PERIODIC:  n_periodic  = i_cfg_data[0];
                CFG_PAIR_MODE: n_pair_mode = i_cfg_data[0];
                default: ;
            endcase
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_cmd == CMD_BUILD) begin
                        n_ket   = '0;
                        n_count = '0;
                        n_w     = '0;
                        n_state = S_BUILD;
                    end else begin
                        n_ket = i_ket_index;
                        if (CW'(i_ket_index) >= CW'(r_count)) begin
                            n_tail    = 1'b1;
                            n_tail_st = ST_RANGE;
                            n_state   = S_TAIL;
                        end else begin
                            n_tail  = 1'b0;
                            n_state = S_SRC_RD;
                        end
                    end
                end
            end
            S_BUILD: begin
                if (tbl_wr_en) begin
                    n_count = r_count + CNT_W'(1);
                end
                n_w = r_w + W'(1);
                if (r_w == last_word) begin
                    n_tail    = 1'b1;
                    n_tail_st = ST_OK;
                    n_state   = S_TAIL;
                end
            end
            S_SRC_RD: begin
                n_state = S_SRC_LATCH;
            end
            S_SRC_LATCH: begin
                n_src   = tbl_rd_data;
                n_j1    = '0;
                n_j2    = '0;
                n_state = S_FLIP;
            end
            S_FLIP: begin
                if (legal) begin
                    n_word  = flip_word;
                    n_wt    = (r_pair_mode && (r_j1 != r_j2)) ? WT_TWO : WT_ONE;
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_state = S_LOOK;
                end else if (row_done) begin
                    n_state = S_TAIL;
                end else if (pair_step) begin
                    n_j2 = r_j2 + JW'(1);
                end else begin
                    n_j1 = r_j1 + JW'(1);
                    n_j2 = r_j1 + JW'(1);
                end
            end
            S_LOOK: begin
                n_mid   = ADDR_W'(mid);
                n_state = S_CMP;
            end
            S_CMP: begin
                n_lo    = lo_nx;
                n_hi    = hi_nx;
                n_state = (lo_nx < hi_nx) ? S_LOOK : S_HIT_RD;
            end
            S_HIT_RD: begin
                n_state = S_HIT_CMP;
            end
            S_HIT_CMP: begin
                if ((r_lo < r_count) && (tbl_rd_data == r_word)) begin
                    n_state = S_PUSH;
                end else begin
                    n_tail    = 1'b1;
                    n_tail_st = ST_MISS;
                    n_state   = S_TAIL;
                end
            end
            S_PUSH: begin
                if (!r_pend_valid || slot_free) begin
                    out_ld       = r_pend_valid;
                    n_pend_valid = 1'b1;
                    n_pend_bra   = ADDR_W'(r_lo);
                    n_pend_wt    = r_wt;
                    if (row_done) begin
                        n_state = S_TAIL;
                    end else begin
                        n_state = S_FLIP;
                        if (pair_step) begin
                            n_j2 = r_j2 + JW'(1);
                        end else begin
                            n_j1 = r_j1 + JW'(1);
                            n_j2 = r_j1 + JW'(1);
                        end
                    end
                end
            end
            S_TAIL: begin
                if (!r_pend_valid && !r_tail) begin
                    // row with no legal flip: nothing to report
                    n_state = S_IDLE;
                end else if (slot_free) begin
                    out_ld = 1'b1;
                    if (r_pend_valid) begin
                        ld_last      = !r_tail;
                        n_pend_valid = 1'b0;
                        if (!r_tail) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        ld_bra  = '0;
                        ld_wt   = WT_NONE;
                        ld_st   = r_tail_st;
                        ld_last = 1'b1;
                        n_tail  = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (out_ld) begin
            n_out_valid = 1'b1;
            n_out_ket   = r_ket;
            n_out_bra   = ld_bra;
            n_out_wt    = ld_wt;
            n_out_size  = r_count;
            n_out_st    = ld_st;
            n_out_last  = ld_last;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_sites  <= NUM_SITES_RST;
            r_periodic   <= PERIODIC_RST;
            r_pair_mode  <= PAIR_MODE_RST;
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_tail       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_num_sites  <= n_num_sites;
            r_periodic   <= n_periodic;
            r_pair_mode  <= n_pair_mode;
            r_state      <= n_state;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_tail       <= n_tail;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_w        <= n_w;
        r_ket      <= n_ket;
        r_src      <= n_src;
        r_j1       <= n_j1;
        r_j2       <= n_j2;
        r_word     <= n_word;
        r_wt       <= n_wt;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_pend_bra <= n_pend_bra;
        r_pend_wt  <= n_pend_wt;
        r_tail_st  <= n_tail_st;
        r_out_ket  <= n_out_ket;
        r_out_bra  <= n_out_bra;
        r_out_wt   <= n_out_wt;
        r_out_size <= n_out_size;
        r_out_st   <= n_out_st;
        r_out_last <= n_out_last;
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_ket_out    = r_out_ket;
    assign o_bra_index  = r_out_bra;
    assign o_weight     = r_out_wt;
    assign o_table_size = r_out_size;
    assign o_status     = r_out_st;
    assign o_last       = r_out_last;

    // a held-back hit never survives past the end of a transaction
    `ASSERT_IMPL(a_idle_no_pend, r_state == S_IDLE, !r_pend_valid, "pending hit left at idle")
    // search window stays inside the filled part of the table
    `ASSERT_IMPL(a_search_window, (r_state == S_LOOK) || (r_state == S_CMP), (r_lo < r_hi) && (r_hi <= r_count), "search window out of bounds")
    // an accepted transaction blocks the input until it completes
    `ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "ready stayed high after accept")
    // error results close the transaction and carry no weight
    `ASSERT_IMPL(a_err_closes, o_out_valid && (o_status != ST_OK), o_last && (o_weight == WT_NONE), "error result not final")
    `ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(TABLE_DEPTH), "table count beyond depth")

endmodule

`default_nettype wire

### tb/sv/constrained_basis_flip_matrix_rows_tb.sv
// ----------------------------------------------------------------------------
// constrained_basis_flip_matrix_rows_tb
// Self-checking bench for the constrained basis table and flip-row generator.
// Directed tests cover the boundary cases; random phases then sweep the
// configuration under random source and sink throttling. A local predictor
// computes every (ket, bra, weight) transaction, and each output transaction
// is matched in order.
// ----------------------------------------------------------------------------
module constrained_basis_flip_matrix_rows_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cbfm_pkg::*;

    localparam int MAX_SITES       = MAX_SITES_DEF;
    localparam int TABLE_DEPTH     = TABLE_DEPTH_DEF;
    localparam int SIZE_W          = $clog2(TABLE_DEPTH + 1);
    localparam int WATCHDOG_LIMIT  = 20000;  // stalled cycles before giving up
    localparam int HOLD_OFF_CYCLES = 600;    // long sink stall for the pressure test
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 25;

    // one output transaction, in port order
    typedef struct packed {
        logic [KET_W-1:0]    ket;
        logic [KET_W-1:0]    bra;
        logic [WEIGHT_W-1:0] weight;
        logic [SIZE_W-1:0]   table_size;
        logic [STATUS_W-1:0] status;
        logic                last;
    } matrix_entry_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input is known from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic                  i_cmd       = CMD_BUILD;
    logic [KET_W-1:0]      i_ket_index = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [KET_W-1:0]      o_ket_out;
    logic [KET_W-1:0]      o_bra_index;
    logic [WEIGHT_W-1:0]   o_weight;
    logic [SIZE_W-1:0]     o_table_size;
    logic [STATUS_W-1:0]   o_status;
    logic                  o_last;

    constrained_basis_flip_matrix_rows u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_ket_index  (i_ket_index),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_ket_out    (o_ket_out),
        .o_bra_index  (o_bra_index),
        .o_weight     (o_weight),
        .o_table_size (o_table_size),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor state: shadow config, shadow table, pending results
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0]     cfg_sites    = NUM_SITES_RST;
    logic                 cfg_periodic = PERIODIC_RST;
    logic                 cfg_pair     = PAIR_MODE_RST;
    logic [MAX_SITES-1:0] basis_words [TABLE_DEPTH];
    int                   basis_count  = 0;
    matrix_entry_t        expected_entries [$];

    // throttling knobs, percent of cycles
    int idle_pct  = 0;
    int stall_pct = 0;

    // pressure test handshake between the test and the sink process
    logic hold_off_armed = 1'b0;
    logic hold_off_done  = 1'b0;

    int mismatch_count = 0;
    int stalled_cycles = 0;
    matrix_entry_t got_entry;
    matrix_entry_t want_entry;

    // No two neighbors set; the wrap pair (n-1, 0) only counts when periodic.
    function automatic bit word_legal(input logic [MAX_SITES-1:0] w, input int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = (i + 1 == n) ? 0 : i + 1;
            if (k == 0 && !cfg_periodic) continue;
            if (w[i] && w[k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Works out every result of one accepted transaction and queues it.
    task automatic predict_item(input logic cmd, input logic [KET_W-1:0] ket);
        int                   n;
        int                   lo;
        int                   hi;
        int                   mid;
        logic [MAX_SITES-1:0] src;
        logic [MAX_SITES-1:0] w;
        matrix_entry_t        held;
        bit                   have_held;

        // out-of-range site counts are clamped, not rejected
        n = (cfg_sites < 2) ? 2 : ((cfg_sites > MAX_SITES) ? MAX_SITES : int'(cfg_sites));

        if (cmd == CMD_BUILD) begin
            basis_count = 0;
            for (int v = 0; v < (1 << n); v++) begin
                if (word_legal(v[MAX_SITES-1:0], n) && basis_count < TABLE_DEPTH) begin
                    basis_words[basis_count] = v[MAX_SITES-1:0];
                    basis_count++;
                end
            end
            expected_entries.push_back('{'0, '0, WT_NONE, SIZE_W'(basis_count), ST_OK, 1'b1});
            return;
        end

        if (int'(ket) >= basis_count) begin
            expected_entries.push_back('{ket, '0, WT_NONE, SIZE_W'(basis_count),
                                         ST_RANGE, 1'b1});
            return;
        end

        // Hold back one entry so the final one of the row can carry last.
        have_held = 1'b0;
        src = basis_words[ket];
        for (int j1 = 0; j1 < n; j1++) begin
            for (int j2 = j1; j2 < n; j2++) begin
                if (!cfg_pair && j2 != j1) break;
                // pair flip with j1 == j2 cancels out: diagonal element
                w = src ^ (MAX_SITES'(1) << j1);
                if (cfg_pair) w = w ^ (MAX_SITES'(1) << j2);
                if (!word_legal(w, n)) continue;
                lo = 0;
                hi = basis_count;
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (basis_words[mid] < w) lo = mid + 1;
                    else hi = mid;
                end
                if (have_held) expected_entries.push_back(held);
                if (!(lo < basis_count && basis_words[lo] == w)) begin
                    // stale table: the row ends on the miss
                    expected_entries.push_back('{ket, '0, WT_NONE, SIZE_W'(basis_count),
                                                 ST_MISS, 1'b1});
                    return;
                end
                held = '{ket, KET_W'(lo), (cfg_pair && j1 != j2) ? WT_TWO : WT_ONE,
                         SIZE_W'(basis_count), ST_OK, 1'b0};
                have_held = 1'b1;
            end
        end
        // a row in range always has at least one legal flip
        held.last = 1'b1;
        expected_entries.push_back(held);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers (always entered and left on a falling edge)
    // ------------------------------------------------------------------------
    task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        case (idx)
            CFG_NUM_SITES: cfg_sites    = data;
            CFG_PERIODIC:  cfg_periodic = data[0];
            CFG_PAIR_MODE: cfg_pair     = data[0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [CFG_W-1:0] sites, input logic periodic,
                                input logic pair);
        write_config(CFG_NUM_SITES, sites);
        write_config(CFG_PERIODIC, CFG_W'(periodic));
        write_config(CFG_PAIR_MODE, CFG_W'(pair));
    endtask

    // Offers one input transaction. Valid stays up afterwards; the next call
    // replaces the payload or drops it, and drain_results drops it at the end.
    task automatic send_item(input logic cmd, input logic [KET_W-1:0] ket);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_cmd       = cmd;
        i_ket_index = ket;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_item(cmd, ket);
        @(negedge i_clk);
    endtask

    // Block is idle once every expected result is in and the last one retires.
    task automatic drain_results();
        i_in_valid = 1'b0;
        while (expected_entries.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset config (10 sites, periodic, pair): rows against an empty table,
    // then a full build and rows at both ends of the table and just past it.
    task automatic test_power_on_defaults();
        idle_pct  = 0;
        stall_pct = 0;
        send_item(CMD_ROW, 8'd0);
        send_item(CMD_ROW, 8'd255);
        send_item(CMD_BUILD, 8'd0);
        send_item(CMD_ROW, 8'd0);
        send_item(CMD_ROW, KET_W'(basis_count - 1));
        send_item(CMD_ROW, KET_W'(basis_count));
        send_item(CMD_ROW, 8'd255);
        drain_results();
    endtask

    // Site counts below 2 and above the maximum are clamped.
    task automatic test_site_count_clamp();
        apply_config(4'd1, 1'b1, 1'b1);
        send_item(CMD_BUILD, 8'd0);
        send_item(CMD_ROW, KET_W'(basis_count - 1));
        drain_results();
        apply_config(4'd15, 1'b0, 1'b0);
        send_item(CMD_BUILD, 8'hFF);
        send_item(CMD_ROW, KET_W'(basis_count - 1));
        drain_results();
    endtask

    // Single flips with an open boundary.
    task automatic test_single_flip_open();
        apply_config(4'd5, 1'b0, 1'b0);
        send_item(CMD_BUILD, 8'd0);
        send_item(CMD_ROW, 8'd0);
        send_item(CMD_ROW, KET_W'(basis_count - 1));
        send_item(CMD_ROW, KET_W'(basis_count));
        drain_results();
    endtask

    // Config changes after a build leave a stale table, so lookups miss:
    // first the wrap pair opens up, then the site count grows.
    task automatic test_stale_table_miss();
        apply_config(4'd6, 1'b1, 1'b1);
        send_item(CMD_BUILD, 8'd0);
        drain_results();
        write_config(CFG_PERIODIC, CFG_W'(1'b0));
        send_item(CMD_ROW, 8'd0);
        send_item(CMD_ROW, 8'd1);
        drain_results();
        apply_config(4'd4, 1'b0, 1'b0);
        send_item(CMD_BUILD, 8'd0);
        drain_results();
        write_config(CFG_NUM_SITES, 4'd6);
        send_item(CMD_ROW, 8'd0);
        drain_results();
    endtask

    // Sink holds off for a long stretch while rows keep coming, so the
    // block fills its output and stops taking input.
    task automatic test_output_hold_off();
        apply_config(4'd10, 1'b1, 1'b1);
        send_item(CMD_BUILD, 8'd0);
        drain_results();
        hold_off_armed = 1'b1;
        send_item(CMD_ROW, 8'd0);
        send_item(CMD_ROW, KET_W'(basis_count / 2));
        send_item(CMD_ROW, KET_W'(basis_count - 1));
        drain_results();
    endtask

    // Random phases: new config each phase, mostly a fresh build followed by
    // rows in range, with some out-of-range kets and rebuilds mixed in. Two
    // phases skip the build and run on the previous table.
    task automatic test_random_phases();
        int               r;
        logic [CFG_W-1:0] sites;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 62;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 62;
                end
                default: begin
                    idle_pct  = 26;
                    stall_pct = 26;
                end
            endcase
            // keep most phases small; one phase runs at the largest sizes
            if (phase == 5) sites = CFG_W'($urandom_range(15, 10));
            else sites = CFG_W'($urandom_range(7, 0));
            apply_config(sites, 1'($urandom_range(1)), 1'($urandom_range(1)));
            if (phase % 4 != 2) send_item(CMD_BUILD, KET_W'($urandom));
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                r = $urandom_range(99);
                if (r < 4) send_item(CMD_BUILD, KET_W'($urandom));
                else if (r < 12 || basis_count == 0) send_item(CMD_ROW, KET_W'($urandom));
                else send_item(CMD_ROW, KET_W'($urandom_range(basis_count - 1)));
            end
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sink: random stalls on the falling edge, plus the one long hold-off
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_armed && !hold_off_done) begin
                i_out_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_done = 1'b1;
            end
            i_out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Checker: every output transaction against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_entry = '{o_ket_out, o_bra_index, o_weight, o_table_size, o_status, o_last};
            if (expected_entries.size() == 0) begin
                $display("%0t: unexpected result ket=%0d bra=%0d wt=%0d size=%0d st=%0d last=%0d",
                         $time, o_ket_out, o_bra_index, o_weight, o_table_size,
                         o_status, o_last);
                mismatch_count++;
            end else begin
                want_entry = expected_entries.pop_front();
                if (got_entry !== want_entry) begin
                    $display("%0t: mismatch expected ket=%0d bra=%0d wt=%0d size=%0d st=%0d last=%0d",
                             $time, want_entry.ket, want_entry.bra, want_entry.weight,
                             want_entry.table_size, want_entry.status, want_entry.last);
                    $display("%0t:          actual   ket=%0d bra=%0d wt=%0d size=%0d st=%0d last=%0d",
                             $time, got_entry.ket, got_entry.bra, got_entry.weight,
                             got_entry.table_size, got_entry.status, got_entry.last);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("constrained_basis_flip_matrix_rows verification failed");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_power_on_defaults();
        test_site_count_clamp();
        test_single_flip_open();
        test_stale_table_miss();
        test_output_hold_off();
        test_random_phases();

        // any stray transaction after the drain still hits the checker
        drain_results();
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("constrained_basis_flip_matrix_rows verification clean");
        end else begin
            $display("constrained_basis_flip_matrix_rows verification failed");
        end
        $finish;
    end

endmodule
